[hdl/npk_pkg.sv]
// Shared types, constants and the byte-to-code function of the nucleotide packer.
package npk_pkg;

	localparam int unsigned CHUNK_BYTES    = 1048576;
	localparam int unsigned BYTES_PER_WORD = 32;
	localparam int unsigned LANES          = BYTES_PER_WORD;
	localparam int unsigned LANE_IDX_W     = $clog2(LANES);

	localparam logic [18:0] SECT_MULT  = 19'(CHUNK_BYTES / BYTES_PER_WORD);
	localparam logic [23:0] CHUNK_MULT = 24'(CHUNK_BYTES);
	localparam logic [20:0] WORD_STEP  = 21'(BYTES_PER_WORD);

	localparam logic [7:0] CHAR_A_UP   = 8'h41;
	localparam logic [7:0] CHAR_A_LO   = 8'h61;
	localparam logic [7:0] CHAR_C_UP   = 8'h43;
	localparam logic [7:0] CHAR_C_LO   = 8'h63;
	localparam logic [7:0] CHAR_G_UP   = 8'h47;
	localparam logic [7:0] CHAR_G_LO   = 8'h67;
	localparam logic [7:0] CHAR_T_UP   = 8'h54;
	localparam logic [7:0] CHAR_T_LO   = 8'h74;
	localparam logic [7:0] CHAR_GAP    = 8'h2D;
	localparam logic [7:0] CHAR_TERM   = 8'h24;

	localparam logic [2:0] CODE_A     = 3'd0;
	localparam logic [2:0] CODE_C     = 3'd1;
	localparam logic [2:0] CODE_G     = 3'd2;
	localparam logic [2:0] CODE_T     = 3'd3;
	localparam logic [2:0] CODE_OTHER = 3'd4;
	localparam logic [2:0] CODE_GAP   = 3'd5;
	localparam logic [2:0] CODE_TERM  = 3'd7;

	typedef struct packed {
		logic [63:0] bytes_lo;
		logic [63:0] bytes_mid_lo;
		logic [63:0] bytes_mid_hi;
		logic [63:0] bytes_hi;
		logic        first_of_chunk;
		logic [3:0]  chunk_number;
		logic [15:0] sequences_in_chunk;
	} word_t;

	typedef struct packed {
		logic [47:0] section_low;
		logic [47:0] section_high;
		logic [18:0] section_address;
		logic        task_valid;
		logic [31:0] task_number;
		logic [23:0] task_offset;
		logic [20:0] task_length;
	} result_t;

	typedef struct packed {
		logic                  found;
		logic [LANE_IDX_W-1:0] index;
	} term_t;

	function automatic logic [2:0] code_of_byte(input logic [7:0] b);
		logic [2:0] c;
		unique case (b) inside
			CHAR_A_UP, CHAR_A_LO: c = CODE_A;
			CHAR_C_UP, CHAR_C_LO: c = CODE_C;
			CHAR_G_UP, CHAR_G_LO: c = CODE_G;
			CHAR_T_UP, CHAR_T_LO: c = CODE_T;
			CHAR_GAP:             c = CODE_GAP;
			CHAR_TERM:            c = CODE_TERM;
			default:              c = CODE_OTHER;
		endcase
		return c;
	endfunction

endpackage

[hdl/npk_lane.sv]
// One decode lane: maps a text byte to its 3-bit code and flags a terminator.
module npk_lane (
	input  logic [7:0] text_byte,
	output logic [2:0] code,
	output logic       term
);

	assign code = npk_pkg::code_of_byte(text_byte);
	assign term = (code == npk_pkg::CODE_TERM);

endmodule

[hdl/npk_merge.sv]
// Decode lanes for a whole word and the merge that packs codes and finds the first terminator.
module npk_merge (
	input  logic [255:0]         text,
	output logic [47:0]          section_low,
	output logic [47:0]          section_high,
	output npk_pkg::term_t       term
);

	logic [npk_pkg::LANES*3-1:0] codes;
	logic [npk_pkg::LANES-1:0]   flags;

	for (genvar j = 0; j < npk_pkg::LANES; j++) begin : g_lane
		npk_lane u_lane (
			.text_byte(text[j*8 +: 8]),
			.code     (codes[j*3 +: 3]),
			.term     (flags[j])
		);
	end

	assign section_low  = codes[47:0];
	assign section_high = codes[95:48];

	always_comb begin
		term.found = |flags;
		term.index = '0;
		for (int k = npk_pkg::LANES - 1; k >= 0; k--) begin
			if (flags[k]) begin
				term.index = npk_pkg::LANE_IDX_W'(k);
			end
		end
	end

endmodule

[hdl/nucleotide_pack_and_split.sv]
// Top level of the nucleotide packer: decode stage, task split stage and result register.
// Two register stages: the stage-one register after the decode and the result register.
// Throughput: one word per cycle while result_stall is low; the 32 decode lanes work in parallel and the
// offset and count update of the split stage is combinational.
// Reset clears both stage valid flags, the chunk position, sequence start,
// sequence count, word count and the running task number.
module nucleotide_pack_and_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  npk_pkg::word_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output npk_pkg::result_t  result
);

	logic [47:0]    sec_low_c;
	logic [47:0]    sec_high_c;
	npk_pkg::term_t term_c;

	logic           valid_s1;
	logic [47:0]    sec_low_s1;
	logic [47:0]    sec_high_s1;
	npk_pkg::term_t term_s1;
	logic           first_s1;
	logic [3:0]     chunk_s1;
	logic [15:0]    seqs_s1;

	logic             result_valid_q;
	npk_pkg::result_t result_q;

	logic [20:0] pos_q;
	logic [20:0] start_q;
	logic [15:0] left_q;
	logic [31:0] task_num_q;
	logic [14:0] word_q;

	logic        adv_out;
	logic        adv_s1;
	logic [20:0] pos_eff;
	logic [20:0] start_eff;
	logic [15:0] left_eff;
	logic [14:0] word_eff;
	logic        emit;
	logic [20:0] end_pos;

	npk_merge u_merge (
		.text        ({item.bytes_hi, item.bytes_mid_hi, item.bytes_mid_lo, item.bytes_lo}),
		.section_low (sec_low_c),
		.section_high(sec_high_c),
		.term        (term_c)
	);

	assign adv_out    = !result_valid_q || !result_stall;
	assign adv_s1     = !valid_s1 || adv_out;
	assign item_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			sec_low_s1  <= sec_low_c;
			sec_high_s1 <= sec_high_c;
			term_s1     <= term_c;
			first_s1    <= item.first_of_chunk;
			chunk_s1    <= item.chunk_number;
			seqs_s1     <= item.sequences_in_chunk;
		end
	end

	assign pos_eff   = first_s1 ? '0 : pos_q;
	assign start_eff = first_s1 ? '0 : start_q;
	assign word_eff  = first_s1 ? '0 : word_q;
	assign left_eff  = first_s1 ? seqs_s1 : left_q;
	assign emit      = term_s1.found && (left_eff != '0);
	assign end_pos   = pos_eff + 21'(term_s1.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pos_q          <= '0;
			start_q        <= '0;
			left_q         <= '0;
			task_num_q     <= '0;
			word_q         <= '0;
		end else if (adv_out) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				pos_q  <= pos_eff + npk_pkg::WORD_STEP;
				word_q <= word_eff + 15'd1;
				if (emit) begin
					start_q    <= end_pos + 21'd1;
					left_q     <= left_eff - 16'd1;
					task_num_q <= task_num_q + 32'd1;
				end else begin
					start_q <= start_eff;
					left_q  <= left_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			result_q.section_low     <= sec_low_s1;
			result_q.section_high    <= sec_high_s1;
			result_q.section_address <= 19'(19'(chunk_s1) * npk_pkg::SECT_MULT) + 19'(word_eff);
			result_q.task_valid      <= emit;
			result_q.task_number     <= emit ? task_num_q : '0;
			result_q.task_offset     <= emit ?
				24'(24'(chunk_s1) * npk_pkg::CHUNK_MULT) + 24'(start_eff) : '0;
			result_q.task_length     <= emit ? end_pos - start_eff : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
